// ===== rtl/core/cpd_pkg.sv =====
// Shared types and constants for the command packet deframer.
package cpd_pkg;

  // Header field positions
  localparam int unsigned TypeHi = 31;
  localparam int unsigned TypeLo = 30;
  localparam int unsigned CountHi = 29;
  localparam int unsigned CountLo = 16;
  localparam int unsigned OpcodeHi = 15;
  localparam int unsigned OpcodeLo = 8;
  localparam int unsigned ReservedHi = 7;

  // Configuration register indexes
  localparam logic [7:0] REG_PROCESS_MAP_OPCODE = 8'd0;
  localparam logic [7:0] REG_QUEUE_MAP_OPCODE = 8'd1;

  // Reset values of the opcode registers
  localparam logic [7:0] PROCESS_MAP_RESET = 8'd161;
  localparam logic [7:0] QUEUE_MAP_RESET = 8'd162;

  // Header type codes
  localparam logic [1:0] TYPE_INVALID = 2'd0;
  localparam logic [1:0] TYPE_ONE = 2'd1;
  localparam logic [1:0] TYPE_TWO = 2'd2;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_BAD_TYPE    = 2'd1,
    ERR_UNSUPPORTED = 2'd2,
    ERR_TRUNCATED   = 2'd3
  } err_code_t;

  typedef struct packed {
    logic [7:0] process_map_opcode;
    logic [7:0] queue_map_opcode;
  } cfg_regs_t;

  typedef struct packed {
    logic        is_header;
    logic [7:0]  packet_opcode;
    logic [14:0] body_length;
    logic [1:0]  header_type;
    logic [13:0] body_position;
    logic [31:0] word_out;
    logic        opcode_supported;
    logic        reserved_set;
    logic        not_type_three;
    err_code_t   first_error;
    logic        buffer_done;
    logic        buffer_ok;
  } result_t;

endpackage

// ===== rtl/core/cpd_parse.sv =====
// Packet framing state and single-pass decode of one command word.
module cpd_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [31:0]        word,
  input  logic               last,
  input  cpd_pkg::cfg_regs_t cfg,
  output cpd_pkg::result_t   result
);

  logic [14:0]        words_remaining, words_remaining_next;
  logic [14:0]        current_length, current_length_next;
  logic [7:0]         current_opcode, current_opcode_next;
  logic [1:0]         current_type, current_type_next;
  cpd_pkg::err_code_t error_code, error_code_next;

  logic        hdr;
  logic [14:0] rem_after;
  logic [14:0] len_sel;
  logic [7:0]  op_sel;
  logic [1:0]  type_sel;
  logic [14:0] pos_full;
  logic        supported;
  cpd_pkg::err_code_t err_hdr;
  cpd_pkg::err_code_t err_final;

  // Decode the word against the current framing state
  always_comb begin
    hdr       = (words_remaining == 15'd0);
    type_sel  = hdr ? word[cpd_pkg::TypeHi:cpd_pkg::TypeLo] : current_type;
    op_sel    = hdr ? word[cpd_pkg::OpcodeHi:cpd_pkg::OpcodeLo] : current_opcode;
    len_sel   = hdr ? ({1'b0, word[cpd_pkg::CountHi:cpd_pkg::CountLo]} + 15'd1)
                    : current_length;
    rem_after = hdr ? len_sel : (words_remaining - 15'd1);
    pos_full  = hdr ? 15'd0 : (current_length - words_remaining);
    supported = (op_sel == cfg.process_map_opcode) || (op_sel == cfg.queue_map_opcode);

    // Keep the first error only
    err_hdr = error_code;
    if (hdr && error_code == cpd_pkg::ERR_NONE) begin
      if (type_sel == cpd_pkg::TYPE_INVALID) begin
        err_hdr = cpd_pkg::ERR_BAD_TYPE;
      end else if (!supported) begin
        err_hdr = cpd_pkg::ERR_UNSUPPORTED;
      end
    end
    err_final = err_hdr;
    if (last && rem_after != 15'd0 && err_hdr == cpd_pkg::ERR_NONE) begin
      err_final = cpd_pkg::ERR_TRUNCATED;
    end

    result.is_header        = hdr;
    result.packet_opcode    = op_sel;
    result.body_length      = len_sel;
    result.header_type      = type_sel;
    result.body_position    = pos_full[13:0];
    result.word_out         = word;
    result.opcode_supported = supported;
    result.reserved_set     = hdr && (word[cpd_pkg::ReservedHi:0] != 8'd0);
    result.not_type_three   = hdr && (type_sel == cpd_pkg::TYPE_ONE ||
                                      type_sel == cpd_pkg::TYPE_TWO);
    result.first_error      = err_final;
    result.buffer_done      = last;
    result.buffer_ok        = last && (err_final == cpd_pkg::ERR_NONE);
  end

  // Next framing state; the last word starts a fresh buffer
  always_comb begin
    if (last) begin
      words_remaining_next = 15'd0;
      current_length_next  = 15'd0;
      current_opcode_next  = 8'd0;
      current_type_next    = 2'd0;
      error_code_next      = cpd_pkg::ERR_NONE;
    end else begin
      words_remaining_next = rem_after;
      current_length_next  = len_sel;
      current_opcode_next  = op_sel;
      current_type_next    = type_sel;
      error_code_next      = err_final;
    end
  end

  // Advance state on each transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      words_remaining <= 15'd0;
      current_length  <= 15'd0;
      current_opcode  <= 8'd0;
      current_type    <= 2'd0;
      error_code      <= cpd_pkg::ERR_NONE;
    end else if (advance) begin
      words_remaining <= words_remaining_next;
      current_length  <= current_length_next;
      current_opcode  <= current_opcode_next;
      current_type    <= current_type_next;
      error_code      <= error_code_next;
    end
  end

endmodule

// ===== rtl/core/command_packet_deframer_core.sv =====
// Top level of the command packet deframer: input register, decode, result register.
//
//   channel | signals                                  | direction
//   input   | in_valid, in_ready, word_in, last_word    | in
//   result  | out_valid, out_ready, is_header .. ok     | out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One word per cycle sustained while the result side accepts; a word passes through
// the input register and then the result register before its result can transfer out.
// rst is synchronous: clears the framing state, the valid flags and reloads the
// opcode registers. A stall at the result side backs up through the input
// register; both stages hold their contents until the next stage has room.
module command_packet_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] word_in,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_header,
  output logic [7:0]  packet_opcode,
  output logic [14:0] body_length,
  output logic [1:0]  header_type,
  output logic [13:0] body_position,
  output logic [31:0] word_out,
  output logic        opcode_supported,
  output logic        reserved_set,
  output logic        not_type_three,
  output logic [1:0]  first_error,
  output logic        buffer_done,
  output logic        buffer_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cpd_pkg::cfg_regs_t cfg;
  cpd_pkg::result_t   result_comb;
  cpd_pkg::result_t   result;

  logic        stage_valid;
  logic [31:0] stage_word;
  logic        stage_last;
  logic        out_room;
  logic        stage_advance;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.process_map_opcode <= cpd_pkg::PROCESS_MAP_RESET;
      cfg.queue_map_opcode   <= cpd_pkg::QUEUE_MAP_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == cpd_pkg::REG_PROCESS_MAP_OPCODE) begin
        cfg.process_map_opcode <= cfg_data;
      end else if (cfg_index == cpd_pkg::REG_QUEUE_MAP_OPCODE) begin
        cfg.queue_map_opcode <= cfg_data;
      end
    end
  end

  // Pipeline handshake
  assign out_room      = !out_valid || out_ready;
  assign stage_advance = stage_valid && out_room;
  assign in_ready      = !stage_valid || out_room;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_word <= word_in;
      stage_last <= last_word;
    end
  end

  cpd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (stage_advance),
    .word    (stage_word),
    .last    (stage_last),
    .cfg     (cfg),
    .result  (result_comb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_room) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance) begin
      result <= result_comb;
    end
  end

  assign is_header        = result.is_header;
  assign packet_opcode    = result.packet_opcode;
  assign body_length      = result.body_length;
  assign header_type      = result.header_type;
  assign body_position    = result.body_position;
  assign word_out         = result.word_out;
  assign opcode_supported = result.opcode_supported;
  assign reserved_set     = result.reserved_set;
  assign not_type_three   = result.not_type_three;
  assign first_error      = result.first_error;
  assign buffer_done      = result.buffer_done;
  assign buffer_ok        = result.buffer_ok;

endmodule
